// ----- sv/gmc_pkg.sv -----
// gmc_pkg: shared types, register indexes and width helpers for the
// gradient mask coverage block. Depends on nothing.
package gmc_pkg;

  // default working fraction bits
  localparam int FRAC_BITS_DEF = 16;

  // configuration port geometry
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // layer_mode bit positions
  localparam int MODE_RADIAL = 0;
  localparam int MODE_INVERT = 1;
  localparam int MODE_ENABLE = 2;

  // register indexes, address bits [5:3]
  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_OPACITY = 3'd1,
    REG_ANCHOR  = 3'd2,
    REG_AXIS    = 3'd3,
    REG_SCALES  = 3'd4,
    REG_RAMP    = 3'd5
  } reg_idx_t;

  // raw register contents as seen by the datapath
  typedef struct packed {
    logic [47:0] ramp;
    logic [47:0] scales;
    logic [35:0] axis;
    logic [39:0] anchor;
    logic [15:0] opacity;
    logic [2:0]  mode;
  } cfg_t;

  // largest pre-root normalizing shift for a given fraction width
  function automatic int gmc_kmax(int f);
    int aw;
    aw = f + 17;
    return (aw > 31) ? aw - 31 : 0;
  endfunction

  // bits needed for the normalizing shift count
  function automatic int gmc_kw(int f);
    int km;
    km = gmc_kmax(f);
    return (km > 0) ? $clog2(km + 1) : 1;
  endfunction

endpackage

// ----- sv/gmc_front.sv -----
// gmc_front: eight-stage geometry pipeline (offset, rotation, axis scaling,
// normalization, squares) plus the full linear ramp. Depends on gmc_pkg.
module gmc_front import gmc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  cfg_t                                  cfg,
  input  logic                                  in_valid,
  input  logic [15:0]                           norm_x,
  input  logic [15:0]                           norm_y,
  input  logic [7:0]                            prior_mix,
  output logic                                  out_valid,
  output logic [62:0]                           out_sum,
  output logic [gmc_kw(FRAC_BITS)-1:0]          out_k,
  output logic signed [FRAC_BITS+8:0]           out_cov_lin,
  output logic [7:0]                            out_prior
);

  localparam int F    = FRAC_BITS;
  localparam int SU   = (F >= 16) ? F - 16 : 0;
  localparam int SD   = (F < 16) ? 16 - F : 0;
  localparam int NS   = 8;
  localparam int DW   = F + 5;
  localparam int CW   = F + 2;
  localparam int PW   = DW + CW;
  localparam int UW   = F + 8;
  localparam int SCW  = F + 8;
  localparam int RW   = UW + SCW + 1;
  localparam int AW   = F + 17;
  localparam int KMAX = gmc_kmax(F);
  localparam int KW   = gmc_kw(F);
  localparam int LVW  = F + 8;
  localparam int LPW  = LVW + 1 + F + 2;
  localparam int CLW  = F + 9;
  localparam int NXW  = 16 + SU;
  localparam int ANW  = 20 + SU;
  localparam int AXW  = 18 + SU;
  localparam int S24W = 24 + SU;
  localparam logic signed [AW:0] ONE_X  = (AW + 1)'(1) << F;
  localparam logic signed [AW:0] HALF_X = (AW + 1)'(1) << (F - 1);

  // lifted operands
  logic [NXW-1:0]          nxw, nyw;
  logic [F-1:0]            nx_l, ny_l;
  logic signed [ANW-1:0]   axw, ayw;
  logic signed [F+3:0]     ax_l, ay_l;
  logic signed [AXW-1:0]   cw, sw;
  logic signed [CW-1:0]    c_l, s_l;
  logic [S24W-1:0]         rmajw, rminw;
  logic [SCW-1:0]          rmaj_l, rmin_l;
  logic signed [S24W-1:0]  svw, evw;
  logic signed [LVW-1:0]   sv_l, ev_l;

  // stage registers
  logic                    vld_r [NS];
  logic [7:0]              pri_r [NS];
  logic signed [DW-1:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [PW-1:0]    pcx_r, psy_r, pcy_r, psx_r;
  logic signed [UW-1:0]    u_r, w_r, u_nxt, w_nxt;
  logic signed [RW-1:0]    pu_r, pw_r;
  logic [AW-1:0]           a_r, b_r, a_nxt, b_nxt;
  logic [F:0]              t_r, t_nxt;
  logic [30:0]             an_r, bn_r, an_nxt, bn_nxt;
  logic [KW-1:0]           k6_r, k7_r, k8_r, k_nxt;
  logic signed [LPW-1:0]   lp_r;
  logic [61:0]             sqa_r, sqb_r;
  logic signed [CLW-1:0]   cl7_r, cl8_r, cl_nxt;
  logic [62:0]             sum_r;

  logic signed [AW-1:0]    rx, ry;
  logic signed [AW:0]      tl;
  logic [AW-1:0]           m;
  logic signed [LVW:0]     ldiff;

  // Q.16 operands moved to the working fraction width
  always_comb begin
    nxw    = NXW'(norm_x) << SU;
    nyw    = NXW'(norm_y) << SU;
    nx_l   = F'(nxw >> SD);
    ny_l   = F'(nyw >> SD);
    axw    = ANW'($signed(cfg.anchor[19:0])) <<< SU;
    ayw    = ANW'($signed(cfg.anchor[39:20])) <<< SU;
    ax_l   = (F + 4)'(axw >>> SD);
    ay_l   = (F + 4)'(ayw >>> SD);
    cw     = AXW'($signed(cfg.axis[17:0])) <<< SU;
    sw     = AXW'($signed(cfg.axis[35:18])) <<< SU;
    c_l    = CW'(cw >>> SD);
    s_l    = CW'(sw >>> SD);
    rmajw  = S24W'(cfg.scales[23:0]) << SU;
    rminw  = S24W'(cfg.scales[47:24]) << SU;
    rmaj_l = SCW'(rmajw >> SD);
    rmin_l = SCW'(rminw >> SD);
    svw    = S24W'($signed(cfg.ramp[23:0])) <<< SU;
    evw    = S24W'($signed(cfg.ramp[47:24])) <<< SU;
    sv_l   = LVW'(svw >>> SD);
    ev_l   = LVW'(evw >>> SD);
  end

  // stage 1: offset from anchor
  always_comb begin
    dx_nxt = DW'($signed({1'b0, nx_l})) - DW'(ax_l);
    dy_nxt = DW'($signed({1'b0, ny_l})) - DW'(ay_l);
  end

  // stage 3: rotate / project
  always_comb begin
    u_nxt = UW'(((PW + 1)'(pcx_r) + (PW + 1)'(psy_r)) >>> F);
    w_nxt = UW'(((PW + 1)'(pcy_r) - (PW + 1)'(psx_r)) >>> F);
  end

  // stage 5: magnitudes and linear position
  always_comb begin
    rx    = AW'(pu_r >>> F);
    ry    = AW'(pw_r >>> F);
    a_nxt = rx[AW-1] ? AW'(-rx) : AW'(rx);
    b_nxt = ry[AW-1] ? AW'(-ry) : AW'(ry);
    tl    = (AW + 1)'(rx) + HALF_X;
    if (tl < 0) begin
      t_nxt = '0;
    end else if (tl > ONE_X) begin
      t_nxt = (F + 1)'(ONE_X);
    end else begin
      t_nxt = (F + 1)'(tl);
    end
  end

  // stage 6: shift both magnitudes below 2^31
  always_comb begin
    m     = a_r | b_r;
    k_nxt = '0;
    for (int i = 0; i < KMAX; i++) begin
      if (m[31 + i]) k_nxt = KW'(i + 1);
    end
    an_nxt = 31'(a_r >> k_nxt);
    bn_nxt = 31'(b_r >> k_nxt);
    ldiff  = (LVW + 1)'(ev_l) - (LVW + 1)'(sv_l);
  end

  // stage 7: linear interpolation result
  always_comb begin
    cl_nxt = CLW'(sv_l) + CLW'(lp_r >>> F);
  end

  // valid and prior travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      pri_r[0] <= prior_mix;
      for (int i = 1; i < NS; i++) pri_r[i] <= pri_r[i-1];
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      pcx_r <= PW'(c_l) * PW'(dx_r);
      psy_r <= PW'(s_l) * PW'(dy_r);
      pcy_r <= PW'(c_l) * PW'(dy_r);
      psx_r <= PW'(s_l) * PW'(dx_r);
      u_r   <= u_nxt;
      w_r   <= w_nxt;
      pu_r  <= RW'(u_r) * RW'($signed({1'b0, rmaj_l}));
      pw_r  <= RW'(w_r) * RW'($signed({1'b0, rmin_l}));
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      t_r   <= t_nxt;
      an_r  <= an_nxt;
      bn_r  <= bn_nxt;
      k6_r  <= k_nxt;
      lp_r  <= LPW'(ldiff) * LPW'($signed({1'b0, t_r}));
      sqa_r <= 62'(an_r) * 62'(an_r);
      sqb_r <= 62'(bn_r) * 62'(bn_r);
      k7_r  <= k6_r;
      cl7_r <= cl_nxt;
      sum_r <= 63'(sqa_r) + 63'(sqb_r);
      k8_r  <= k7_r;
      cl8_r <= cl7_r;
    end
  end

  assign out_valid   = vld_r[NS-1];
  assign out_sum     = sum_r;
  assign out_k       = k8_r;
  assign out_cov_lin = cl8_r;
  assign out_prior   = pri_r[NS-1];

endmodule

// ----- sv/gmc_isqrt.sv -----
// gmc_isqrt: 32-stage pipelined floor square root of a 63-bit value, one
// result bit per stage, with a sideband that rides along. Depends on gmc_pkg.
module gmc_isqrt import gmc_pkg::*; #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [62:0]   in_x,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);

  localparam int NS = 32;

  logic          vld_r  [NS];
  logic [SW-1:0] side_r [NS];
  logic [62:0]   rem_r  [NS];
  logic [62:0]   res_r  [NS];
  logic [62:0]   rem_q  [NS+1];
  logic [62:0]   res_q  [NS+1];
  logic [62:0]   rem_nxt [NS];
  logic [62:0]   res_nxt [NS];

  // stage inputs: the incoming value, then each stage's registers
  always_comb begin
    rem_q[0] = in_x;
    res_q[0] = '0;
    for (int j = 0; j < NS; j++) begin
      rem_q[j+1] = rem_r[j];
      res_q[j+1] = res_r[j];
    end
  end

  // one compare-subtract per stage
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int j = 0; j < NS; j++) begin
      bitv  = 64'(1) << (62 - 2 * j);
      trial = 64'(res_q[j]) + bitv;
      if (64'(rem_q[j]) >= trial) begin
        rem_nxt[j] = 63'(64'(rem_q[j]) - trial);
        res_nxt[j] = 63'((64'(res_q[j]) >> 1) + bitv);
      end else begin
        rem_nxt[j] = rem_q[j];
        res_nxt[j] = res_q[j] >> 1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < NS; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  // remainder, partial root and sideband
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int j = 1; j < NS; j++) side_r[j] <= side_r[j-1];
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= rem_nxt[j];
        res_r[j] <= res_nxt[j];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = res_r[NS-1][31:0];
  assign out_side  = side_r[NS-1];

endmodule

// ----- sv/gmc_back.sv -----
// gmc_back: five-stage tail: feather ramp, mode select, inversion, opacity,
// quantization and max with the prior value. Depends on gmc_pkg.
module gmc_back import gmc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  input  logic [31:0]                   in_root,
  input  logic [gmc_kw(FRAC_BITS)-1:0]  in_k,
  input  logic signed [FRAC_BITS+8:0]   in_cov_lin,
  input  logic [7:0]                    in_prior,
  output logic                          out_valid,
  output logic [7:0]                    out_mix
);

  localparam int F    = FRAC_BITS;
  localparam int SU   = (F >= 16) ? F - 16 : 0;
  localparam int SD   = (F < 16) ? 16 - F : 0;
  localparam int NS   = 5;
  localparam int KMAX = gmc_kmax(F);
  localparam int RHW  = 32 + KMAX;
  localparam int SCW  = F + 8;
  localparam int DIW  = ((RHW > SCW) ? RHW : SCW) + 1;
  localparam int PRW  = DIW - 1 + SCW;
  localparam int CLW  = F + 9;
  localparam int CVW  = CLW + 1;
  localparam int OPW  = CVW + 17;
  localparam int VSW  = OPW - 15;
  localparam int QSW  = F + 9;
  localparam int S24W = 24 + SU;
  localparam logic [PRW-1:0]        LIM    = PRW'(1) << (2 * F);
  localparam logic [F:0]            ONE_T  = (F + 1)'(1) << F;
  localparam logic signed [CVW-1:0] ONE_C  = CVW'(1) << F;
  localparam logic signed [VSW-1:0] ONE_V  = VSW'(1) << F;
  localparam logic [QSW-1:0]        HALF_Q = QSW'(1) << (F - 1);

  logic [S24W-1:0]        innw, spnw;
  logic [SCW-1:0]         inner_l, rspan_l;

  logic                   vld_r [NS];
  logic [7:0]             pri_r [NS-1];
  logic signed [CLW-1:0]  cl1_r, cl2_r;
  logic [DIW-2:0]         dp_r, dp_nxt;
  logic [PRW-1:0]         pr_r;
  logic signed [CVW-1:0]  cov_r, cov_nxt;
  logic signed [OPW-1:0]  op_r;
  logic [7:0]             mix_r, mix_nxt;

  logic [RHW-1:0]         rho;
  logic signed [DIW-1:0]  d;
  logic [F:0]             t;
  logic signed [VSW-1:0]  vs;
  logic [F:0]             v;
  logic [QSW-1:0]         qs;
  logic [8:0]             q9;
  logic [7:0]             q;

  // radial ramp terms in working format
  always_comb begin
    innw    = S24W'(cfg.ramp[23:0]) << SU;
    spnw    = S24W'(cfg.ramp[47:24]) << SU;
    inner_l = SCW'(innw >> SD);
    rspan_l = SCW'(spnw >> SD);
  end

  // stage 1: undo normalization, distance past the inner edge
  always_comb begin
    rho    = RHW'(in_root) << in_k;
    d      = $signed(DIW'(rho)) - $signed(DIW'(inner_l));
    dp_nxt = (d <= 0) ? '0 : d[DIW-2:0];
  end

  // stage 3: saturated feather ramp, mode select, inversion
  always_comb begin
    if (pr_r > LIM) begin
      t = ONE_T;
    end else begin
      t = (F + 1)'(pr_r >> F);
    end
    if (cfg.mode[MODE_RADIAL]) begin
      cov_nxt = $signed(CVW'(ONE_T - t));
    end else begin
      cov_nxt = CVW'(cl2_r);
    end
    if (cfg.mode[MODE_INVERT]) cov_nxt = ONE_C - cov_nxt;
  end

  // stage 5: clamp, round to 8 bits, combine with prior
  always_comb begin
    vs = VSW'(op_r >>> 15);
    if (vs < 0) begin
      v = '0;
    end else if (vs > ONE_V) begin
      v = ONE_T;
    end else begin
      v = (F + 1)'(vs);
    end
    qs = (QSW'(v) << 8) - QSW'(v) + HALF_Q;
    q9 = 9'(qs >> F);
    q  = (q9 > 9'd255) ? 8'd255 : q9[7:0];
    if (!cfg.mode[MODE_ENABLE]) begin
      mix_nxt = pri_r[NS-2];
    end else begin
      mix_nxt = (q > pri_r[NS-2]) ? q : pri_r[NS-2];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      pri_r[0] <= in_prior;
      for (int i = 1; i < NS - 1; i++) pri_r[i] <= pri_r[i-1];
      cl1_r <= in_cov_lin;
      dp_r  <= dp_nxt;
      cl2_r <= cl1_r;
      pr_r  <= PRW'(dp_r) * PRW'(rspan_l);
      cov_r <= cov_nxt;
      op_r  <= OPW'(cov_r) * OPW'($signed({1'b0, cfg.opacity}));
      mix_r <= mix_nxt;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_mix   = mix_r;

endmodule

// ----- sv/gradient_mask_coverage.sv -----
// gradient_mask_coverage: top level with register file, pipeline hookup and
// output skid stage. Depends on gmc_pkg, gmc_front, gmc_isqrt, gmc_back.
//
// Usage: one pixel item per clock on the in_ channel (valid/ready) carries
// normalized coordinates and the prior mask value; the out_ channel returns
// mix_value, the max of the prior and this layer's 8-bit coverage.
// Layer registers sit on the APB-style port, 64-bit data, register i at
// byte address 8*i; write them only while no item is in flight.
// Path from acceptance to out_valid: 8 geometry stages, 32 square-root
// stages, 5 ramp/opacity stages. Throughput: one item per cycle while the
// skid register is empty, set by the fully pipelined root unit.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults: layer disabled, opacity one, everything else zero.
// When the receiver stalls, the last result moves into a skid register and
// the pipeline freezes once it is loaded; in_ready drops only while the skid
// register is full, so nothing is lost or repeated.
module gradient_mask_coverage import gmc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_norm_x,
  input  logic [15:0]       in_norm_y,
  input  logic [7:0]        in_prior_mix,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_mix_value,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int KW  = gmc_kw(FRAC_BITS);
  localparam int CLW = FRAC_BITS + 9;
  localparam int SW  = KW + CLW + 8;

  cfg_t                  cfg_r;
  reg_idx_t              idx;
  logic                  wr_en;
  logic                  en;

  logic                  f_valid;
  logic [62:0]           f_sum;
  logic [KW-1:0]         f_k;
  logic signed [CLW-1:0] f_cl;
  logic [7:0]            f_prior;
  logic [SW-1:0]         q_side_in, q_side_out;
  logic                  q_valid;
  logic [31:0]           q_root;
  logic                  b_valid;
  logic [7:0]            b_mix;

  logic                  skid_v_r;
  logic [7:0]            skid_d_r;

  // register file
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= '0;
      cfg_r.opacity <= 16'd32768;
      cfg_r.anchor  <= '0;
      cfg_r.axis    <= '0;
      cfg_r.scales  <= '0;
      cfg_r.ramp    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:    cfg_r.mode    <= pwdata[2:0];
        REG_OPACITY: cfg_r.opacity <= pwdata[15:0];
        REG_ANCHOR:  cfg_r.anchor  <= pwdata[39:0];
        REG_AXIS:    cfg_r.axis    <= pwdata[35:0];
        REG_SCALES:  cfg_r.scales  <= pwdata[47:0];
        REG_RAMP:    cfg_r.ramp    <= pwdata[47:0];
        default:     ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_MODE:    prdata = DATA_W'(cfg_r.mode);
      REG_OPACITY: prdata = DATA_W'(cfg_r.opacity);
      REG_ANCHOR:  prdata = DATA_W'(cfg_r.anchor);
      REG_AXIS:    prdata = DATA_W'(cfg_r.axis);
      REG_SCALES:  prdata = DATA_W'(cfg_r.scales);
      REG_RAMP:    prdata = DATA_W'(cfg_r.ramp);
      default:     prdata = '0;
    endcase
  end

  // pipeline advances whenever the skid register is empty
  assign en       = ~skid_v_r;
  assign in_ready = en;

  gmc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .norm_x      (in_norm_x),
    .norm_y      (in_norm_y),
    .prior_mix   (in_prior_mix),
    .out_valid   (f_valid),
    .out_sum     (f_sum),
    .out_k       (f_k),
    .out_cov_lin (f_cl),
    .out_prior   (f_prior)
  );

  assign q_side_in = {f_k, f_cl, f_prior};

  gmc_isqrt #(.SW(SW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_x      (f_sum),
    .in_side   (q_side_in),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_side_out)
  );

  gmc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .in_valid   (q_valid),
    .in_root    (q_root),
    .in_k       (q_side_out[SW-1 -: KW]),
    .in_cov_lin ($signed(q_side_out[CLW+7:8])),
    .in_prior   (q_side_out[7:0]),
    .out_valid  (b_valid),
    .out_mix    (b_mix)
  );

  // output skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) skid_v_r <= 1'b0;
    end else if (b_valid && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) skid_d_r <= b_mix;
  end

  assign out_valid     = skid_v_r | b_valid;
  assign out_mix_value = skid_v_r ? skid_d_r : b_mix;

endmodule

// ----- verif/gradient_mask_coverage_tb.sv -----
// gradient_mask_coverage_tb: self-checking bench for one mask layer's coverage.
// Depends on gmc_pkg and gradient_mask_coverage. Directed corners, then random
// register settings with random pixel items; results are checked in order.
module gradient_mask_coverage_tb;
  import gmc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int PIPE_LAT = 45;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  prior;
  } pixel_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] in_norm_x, in_norm_y;
  logic [7:0] in_prior_mix, out_mix_value;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  // shadow copy of the layer registers
  logic [2:0]  lay_mode;
  logic [15:0] lay_opacity;
  logic [39:0] lay_anchor;
  logic [35:0] lay_axis;
  logic [47:0] lay_scales;
  logic [47:0] lay_ramp;

  pixel_t pixel_queue[$];
  logic [7:0] mix_expected[$];
  int errors;
  bit idle_on;
  int send_gap, recv_stall;

  gradient_mask_coverage u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_prior_mix(in_prior_mix),
    .out_valid(out_valid), .out_ready(out_ready), .out_mix_value(out_mix_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(3_000_000 * 10);
    $display("FAIL");
    $finish;
  end

  // floor shift toward minus infinity
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint radial_coverage(longint dx, longint dy);
    longint c, s, rmaj, rmin, inner, rspan, u, w, rx, ry, rho, d, t;
    longint unsigned a, b, lim;
    int k;
    c = $signed(lay_axis[17:0]);
    s = $signed(lay_axis[35:18]);
    rmaj = lay_scales[23:0];
    rmin = lay_scales[47:24];
    inner = lay_ramp[23:0];
    rspan = lay_ramp[47:24];
    u = floor_shr(c * dx + s * dy, FB);
    w = floor_shr(c * dy - s * dx, FB);
    rx = floor_shr(u * rmaj, FB);
    ry = floor_shr(w * rmin, FB);
    a = (rx < 0) ? -rx : rx;
    b = (ry < 0) ? -ry : ry;
    k = 0;
    // normalize so the squares fit in 64 bits
    while ((a >> 31) != 0 || (b >> 31) != 0) begin
      a >>= 1;
      b >>= 1;
      k++;
    end
    rho = longint'(int_sqrt(a * a + b * b) << k);
    d = rho - inner;
    if (d <= 0 || rspan <= 0) begin
      t = 0;
    end else begin
      lim = (64'd1 << (2 * FB)) / longint'(rspan);
      if (longint'(d) > lim) t = ONE;
      else t = clamp_one(floor_shr(d * rspan, FB));
    end
    return ONE - t;
  endfunction

  function automatic longint linear_coverage(longint dx, longint dy);
    longint nvx, nvy, rtr, sv, ev, proj, t;
    nvx = $signed(lay_axis[17:0]);
    nvy = $signed(lay_axis[35:18]);
    rtr = lay_scales[23:0];
    sv = $signed(lay_ramp[23:0]);
    ev = $signed(lay_ramp[47:24]);
    proj = floor_shr(dx * nvx + dy * nvy, FB);
    t = clamp_one(floor_shr(proj * rtr, FB) + ONE / 2);
    return sv + floor_shr((ev - sv) * t, FB);
  endfunction

  function automatic logic [7:0] predict_mix(pixel_t p);
    longint dx, dy, cov, v;
    longint unsigned q;
    if (!lay_mode[MODE_ENABLE]) return p.prior;
    dx = longint'(p.x) - longint'($signed(lay_anchor[19:0]));
    dy = longint'(p.y) - longint'($signed(lay_anchor[39:20]));
    cov = lay_mode[MODE_RADIAL] ? radial_coverage(dx, dy) : linear_coverage(dx, dy);
    if (lay_mode[MODE_INVERT]) cov = ONE - cov;
    v = clamp_one(floor_shr(cov * longint'(lay_opacity), 15));
    q = (longint'(v) * 255 + ONE / 2) >> FB;
    if (q > 255) q = 255;
    return (q > p.prior) ? q[7:0] : p.prior;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // driver: present queued items, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        mix_expected.push_back(predict_mix('{in_norm_x, in_norm_y, in_prior_mix}));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        in_norm_x <= p.x;
        in_norm_y <= p.y;
        in_prior_mix <= p.prior;
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mix_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected mix_value %0d", out_mix_value));
        end else begin
          logic [7:0] want;
          want = mix_expected.pop_front();
          if (out_mix_value !== want)
            report_mismatch($sformatf("mix_value %0d, expected %0d", out_mix_value, want));
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 19) == 0) recv_stall <= $urandom_range(1, 15);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:    lay_mode = val[2:0];
      REG_OPACITY: lay_opacity = val[15:0];
      REG_ANCHOR:  lay_anchor = val[39:0];
      REG_AXIS:    lay_axis = val[35:0];
      REG_SCALES:  lay_scales = val[47:0];
      REG_RAMP:    lay_ramp = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_layer(logic [2:0] m, logic [15:0] op, logic [39:0] an,
                           logic [35:0] ax, logic [47:0] sc, logic [47:0] rp);
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_OPACITY, 64'(op));
    write_reg(REG_ANCHOR, 64'(an));
    write_reg(REG_AXIS, 64'(ax));
    write_reg(REG_SCALES, 64'(sc));
    write_reg(REG_RAMP, 64'(rp));
  endtask

  task automatic add_pixel(logic [15:0] x, logic [15:0] y, logic [7:0] pr);
    pixel_queue.push_back('{x, y, pr});
  endtask

  // wait until every item is sent and answered, then let the pipe settle;
  // checked between edges so driver updates of the same edge are seen
  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || mix_expected.size() > 0)
      @(negedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic add_corners();
    add_pixel(16'h0000, 16'h0000, 8'd0);
    add_pixel(16'hFFFF, 16'hFFFF, 8'd0);
    add_pixel(16'h0000, 16'hFFFF, 8'd255);
    add_pixel(16'hFFFF, 16'h0000, 8'd128);
    add_pixel(16'h8000, 16'h8000, 8'd0);
  endtask

  task automatic random_layer();
    logic [2:0] m;
    logic [15:0] op;
    logic [19:0] ax_x, ax_y;
    logic [17:0] cs, sn;
    logic [23:0] s0, s1, r0, r1;
    m = {($urandom_range(0, 5) != 0), 2'($urandom_range(0, 3))};
    case ($urandom_range(0, 3))
      0: op = 16'd32768;
      1: op = 16'($urandom_range(0, 32768));
      2: op = 16'hFFFF;
      default: op = 16'($urandom);
    endcase
    ax_x = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 65536));
    ax_y = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 65536));
    cs = 18'($urandom);
    sn = 18'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      cs = 18'd65536;
      sn = 18'd0;
    end
    s0 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 393216));
    s1 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 393216));
    r0 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536));
    r1 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 524288));
    set_layer(m, op, {ax_y, ax_x}, {sn, cs}, {s1, s0}, {r1, r0});
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_norm_x = '0;
    in_norm_y = '0;
    in_prior_mix = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    lay_mode = 3'd0;
    lay_opacity = 16'd32768;
    lay_anchor = '0;
    lay_axis = '0;
    lay_scales = '0;
    lay_ramp = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // disabled layer after reset: prior passes through
    add_pixel(16'h1234, 16'h4321, 8'd0);
    add_pixel(16'hFFFF, 16'hFFFF, 8'd255);
    add_pixel(16'h0000, 16'h0000, 8'd77);
    drain();

    // radial ellipse centered, inner edge and feather
    set_layer(3'b101, 16'd32768, {20'd32768, 20'd32768}, {18'd0, 18'd65536},
              {24'd131072, 24'd196608}, {24'd262144, 24'd16384});
    add_corners();
    add_pixel(16'h9000, 16'h8000, 8'd10);
    drain();

    // radial with zero feather reciprocal, inverted, rotated
    set_layer(3'b111, 16'd16384, {20'hFFFFF, 20'd65536}, {18'd46341, 18'd46341},
              {24'd65536, 24'd65536}, {24'd0, 24'd8192});
    add_corners();
    drain();

    // linear with zero transition reciprocal: midpoint value
    set_layer(3'b100, 16'd32768, {20'd0, 20'd0}, {18'd0, 18'd65536},
              {24'd0, 24'd0}, {24'd65536, 24'hFF0000});
    add_corners();
    drain();

    // linear inverted with opacity gain above one
    set_layer(3'b110, 16'hFFFF, {20'd32768, 20'd32768}, {18'h3FFFF, 18'd65536},
              {24'd0, 24'd131072}, {24'h7FFFFF, 24'h800000});
    add_corners();
    drain();

    // every register at all ones, then enabled with zeros
    set_layer(3'h7, 16'hFFFF, {40{1'b1}}, {36{1'b1}}, {48{1'b1}}, {48{1'b1}});
    add_corners();
    drain();
    set_layer(3'b101, 16'h0000, '0, '0, '0, '0);
    add_corners();
    drain();

    // random layers with random pixels; last one without idling
    for (int ph = 0; ph < 9; ph++) begin
      random_layer();
      if (ph == 8) idle_on = 1'b0;
      for (int i = 0; i < 100; i++)
        add_pixel(16'($urandom), 16'($urandom),
                  ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0);
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gmc_pkg.sv
sv/gmc_front.sv
sv/gmc_isqrt.sv
sv/gmc_back.sv
sv/gradient_mask_coverage.sv
verif/gradient_mask_coverage_tb.sv
